// File: rtl/rod_pkg.sv
`default_nettype none
package rod_pkg;

    // frame limits
    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int DEPTH     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // field widths
    localparam int FIELD_W   = 12;
    localparam int CFG_W     = 7;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 13;
    localparam int COORD_W   = 14;   // holds anchor + span +/- 1
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 24;

    // register indexes
    localparam logic REG_FRAME_COLS = 1'b0;
    localparam logic REG_FRAME_ROWS = 1'b1;

    // opcodes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } rod_mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             outside;
        logic [CNT_W-1:0] count;
    } rod_res_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input coord_t col, input coord_t row);
        logic [ADDR_W-1:0] r_a;
        logic [ADDR_W-1:0] c_a;
        r_a = ADDR_W'(row[ROW_W-1:0]);
        c_a = ADDR_W'(col[COL_W-1:0]);
        return ADDR_W'(r_a * ADDR_W'(MAX_COLS)) + c_a;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rod_ram.sv
`default_nettype none
module rod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: rtl/rod_draw.sv
`default_nettype none
module rod_draw (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_tuser,
    input  wire logic [rod_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [rod_pkg::CFG_W-1:0]     frame_cols,
    input  wire logic [rod_pkg::CFG_W-1:0]     frame_rows,
    output rod_pkg::rod_mem_req_t              mem_req,
    input  wire logic [rod_pkg::PIX_W-1:0]     mem_rdata,
    output rod_pkg::rod_res_t                  res,
    input  wire logic                          res_ready
);
    import rod_pkg::*;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_SETUP = 11'b00000000100,
        ST_CLIP  = 11'b00000001000,
        ST_ROW   = 11'b00000010000,
        ST_HLINE = 11'b00000100000,
        ST_LEFT  = 11'b00001000000,
        ST_RIGHT = 11'b00010000000,
        ST_RD    = 11'b00100000000,
        ST_RWAIT = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic                      op_reg, op_next;
    logic signed [FIELD_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [FIELD_W-1:0] sw_reg, sw_next, sh_reg, sh_next;
    logic [PIX_W-1:0]          color_reg, color_next;
    coord_t clo_reg, clo_next, chi_reg, chi_next, rlo_reg, rlo_next, rhi_reg, rhi_next;
    coord_t c0_reg, c0_next, c1_reg, c1_next, r1_reg, r1_next;
    coord_t row_reg, row_next, col_reg, col_next;
    coord_t ecols_reg, ecols_next, erows_reg, erows_next;
    logic                      empty_reg, empty_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PIX_W-1:0]          pix_reg, pix_next;
    logic                      out_reg, out_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;

    coord_t ax_w, ay_w, sw_w, sh_w, fc_w, fr_w;
    coord_t csum, rsum;
    logic   clear_last;
    logic   clo_in, chi_in, rd_in;
    logic [CNT_W-1:0] cnt_inc;

    assign ax_w = COORD_W'(ax_reg);
    assign ay_w = COORD_W'(ay_reg);
    assign sw_w = COORD_W'(sw_reg);
    assign sh_w = COORD_W'(sh_reg);
    assign fc_w = $signed(COORD_W'(frame_cols));
    assign fr_w = $signed(COORD_W'(frame_rows));
    assign csum = ax_w + sw_w;
    assign rsum = ay_w + sh_w;

    assign clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign clo_in     = (clo_reg >= 0) && (clo_reg < ecols_reg);
    assign chi_in     = (chi_reg >= 0) && (chi_reg < ecols_reg);
    assign rd_in      = (ax_w >= 0) && (ay_w >= 0) && (ax_w < ecols_reg) && (ay_w < erows_reg);
    assign cnt_inc    = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        sw_next       = sw_reg;
        sh_next       = sh_reg;
        color_next    = color_reg;
        clo_next      = clo_reg;
        chi_next      = chi_reg;
        rlo_next      = rlo_reg;
        rhi_next      = rhi_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        r1_next       = r1_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        ecols_next    = ecols_reg;
        erows_next    = erows_reg;
        empty_next    = empty_reg;
        cnt_next      = cnt_reg;
        pix_next      = pix_reg;
        out_next      = out_reg;
        clr_addr_next = clr_addr_reg;
        mem_req.we    = 1'b0;
        mem_req.addr  = pix_addr(col_reg, row_reg);
        mem_req.wdata = color_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_addr_reg;
                mem_req.wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    ax_next    = $signed(s_tdata[11:0]);
                    ay_next    = $signed(s_tdata[23:12]);
                    sw_next    = $signed(s_tdata[35:24]);
                    sh_next    = $signed(s_tdata[47:36]);
                    color_next = s_tdata[55:48];
                    cnt_next   = '0;
                    pix_next   = '0;
                    out_next   = 1'b0;
                    state_next = (s_tuser == OP_READ) ? ST_RD : ST_SETUP;
                end
                ecols_next = (fc_w > COORD_W'(MAX_COLS)) ? COORD_W'(MAX_COLS) : fc_w;
                erows_next = (fr_w > COORD_W'(MAX_ROWS)) ? COORD_W'(MAX_ROWS) : fr_w;
            end
            ST_SETUP: begin
                empty_next = (sw_reg == 0) || (sh_reg == 0);
                if (sw_reg > 0) begin
                    clo_next = ax_w;
                    chi_next = csum - COORD_W'(1);
                end else begin
                    clo_next = csum + COORD_W'(1);
                    chi_next = ax_w;
                end
                if (sh_reg > 0) begin
                    rlo_next = ay_w;
                    rhi_next = rsum - COORD_W'(1);
                end else begin
                    rlo_next = rsum + COORD_W'(1);
                    rhi_next = ay_w;
                end
                state_next = ST_CLIP;
            end
            ST_CLIP: begin
                row_next   = (rlo_reg < 0) ? '0 : rlo_reg;
                r1_next    = (rhi_reg > erows_reg - COORD_W'(1)) ? erows_reg - COORD_W'(1)
                                                                 : rhi_reg;
                c0_next    = (clo_reg < 0) ? '0 : clo_reg;
                c1_next    = (chi_reg > ecols_reg - COORD_W'(1)) ? ecols_reg - COORD_W'(1)
                                                                 : chi_reg;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                priority if (empty_reg || (row_reg > r1_reg)) begin
                    state_next = ST_DONE;
                end else if ((row_reg == rlo_reg) || (row_reg == rhi_reg)) begin
                    col_next   = c0_reg;
                    state_next = ST_HLINE;
                end else begin
                    state_next = ST_LEFT;
                end
            end
            ST_HLINE: begin
                if (col_reg <= c1_reg) begin
                    mem_req.we = 1'b1;
                    cnt_next   = cnt_inc;
                    col_next   = col_reg + COORD_W'(1);
                end else begin
                    row_next   = row_reg + COORD_W'(1);
                    state_next = ST_ROW;
                end
            end
            ST_LEFT: begin
                mem_req.addr = pix_addr(clo_reg, row_reg);
                if (clo_in) begin
                    mem_req.we = 1'b1;
                    cnt_next   = cnt_inc;
                end
                if (chi_reg != clo_reg) begin
                    state_next = ST_RIGHT;
                end else begin
                    row_next   = row_reg + COORD_W'(1);
                    state_next = ST_ROW;
                end
            end
            ST_RIGHT: begin
                mem_req.addr = pix_addr(chi_reg, row_reg);
                if (chi_in) begin
                    mem_req.we = 1'b1;
                    cnt_next   = cnt_inc;
                end
                row_next   = row_reg + COORD_W'(1);
                state_next = ST_ROW;
            end
            ST_RD: begin
                mem_req.addr = pix_addr(ax_w, ay_w);
                if (rd_in) begin
                    state_next = ST_RWAIT;
                end else begin
                    out_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_RWAIT: begin
                pix_next   = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid   = (state_reg == ST_DONE);
    assign res.pixel   = pix_reg;
    assign res.outside = out_reg;
    assign res.count   = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sw_reg    <= sw_next;
        sh_reg    <= sh_next;
        color_reg <= color_next;
        clo_reg   <= clo_next;
        chi_reg   <= chi_next;
        rlo_reg   <= rlo_next;
        rhi_reg   <= rhi_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        r1_reg    <= r1_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        ecols_reg <= ecols_next;
        erows_reg <= erows_next;
        empty_reg <= empty_next;
        cnt_reg   <= cnt_next;
        pix_reg   <= pix_next;
        out_reg   <= out_next;
    end

    // memory is only written by the clear sweep or the outline walk
    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (state_reg == ST_CLEAR || state_reg == ST_HLINE ||
                        state_reg == ST_LEFT || state_reg == ST_RIGHT))
        else $error("frame write outside clear or draw");

    a_clear_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !clear_last) |=> (state_reg == ST_CLEAR))
        else $error("clear sweep left early");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && op_reg == OP_READ) |-> (res.count == '0))
        else $error("read result carries a pixel count");

    a_draw_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && op_reg == OP_DRAW) |-> (res.pixel == '0 && !res.outside))
        else $error("draw result carries read fields");

endmodule
`default_nettype wire

// File: rtl/rectangle_outline_drawer.sv
// Read request: passes ST_RD and ST_RWAIT (ST_RWAIT skipped when outside the frame) to
// ST_DONE, then the output register raises m_tvalid. Draw request: ST_SETUP and ST_CLIP,
// then per clipped row an ST_ROW step and the outline positions walked (plus an ST_HLINE
// exit step on top or bottom edge rows); the walker writes one pixel per cycle through the single frame memory port.
// One request at a time; the next is taken while the previous result waits at m_.
// aresetn (synchronous, active low) clears control state and then starts a clear sweep
// of all 4096 frame memory pixels, one pixel per cycle; s_tready stays low until done.
`default_nettype none
module rectangle_outline_drawer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [11:0] anchor_col, [23:12] anchor_row, [35:24] span_cols, [47:36] span_rows,
    // [55:48] pen_color
    input  wire logic [rod_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] pixel_value, [20:8] drawn_count, zero above
    output logic      [rod_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] outside_frame
    output logic                               m_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [rod_pkg::CFG_W-1:0]     cfg_wr_data
);
    import rod_pkg::*;

    logic [CFG_W-1:0] frame_cols_reg, frame_rows_reg;
    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_pix_reg;
    logic [CNT_W-1:0] m_cnt_reg;
    logic             m_out_reg;
    logic             res_ready;
    logic             res_load;
    logic [PIX_W-1:0] mem_rdata;
    rod_mem_req_t     mem_req;
    rod_res_t         res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= CFG_W'(64);
            frame_rows_reg <= CFG_W'(64);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_COLS: frame_cols_reg <= cfg_wr_data;
                REG_FRAME_ROWS: frame_rows_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    rod_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (aclk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    rod_draw u_draw (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .frame_cols (frame_cols_reg),
        .frame_rows (frame_rows_reg),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res        (res),
        .res_ready  (res_ready)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;
    assign res_load  = res.valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_pix_reg <= res.pixel;
            m_cnt_reg <= res.count;
            m_out_reg <= res.outside;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - PIX_W - CNT_W)'(0), m_cnt_reg, m_pix_reg};
    assign m_tuser  = m_out_reg;

endmodule
`default_nettype wire

// File: dv/rectangle_outline_drawer_tb.sv
`default_nettype none
module rectangle_outline_drawer_tb;
    import rod_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic               op;
        logic signed [11:0] col;
        logic signed [11:0] row;
        logic signed [11:0] wid;
        logic signed [11:0] hgt;
        logic [7:0]         color;
    } pix_req_t;

    typedef struct packed {
        logic [7:0]  pixel;
        logic        outside;
        logic [12:0] count;
    } pix_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic                  cfg_addr    = REG_FRAME_COLS;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    rectangle_outline_drawer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // shadow frame and registers
    logic [7:0]  frame_px [0:DEPTH-1];
    int unsigned reg_cols = 64;
    int unsigned reg_rows = 64;

    pix_req_t pend_q [$];
    pix_res_t result_q [$];
    pix_req_t cur;

    int  mismatches = 0;
    bit  no_idle    = 1'b0;
    bit  hold_req   = 1'b0;
    bit  hold_done  = 1'b0;
    int  hold_left  = 0;
    int  send_gap   = 0;
    int  sink_gap   = 0;

    initial begin
        for (int i = 0; i < DEPTH; i++) frame_px[i] = 8'h00;
    end

    function automatic int cols_in_use();
        return (reg_cols > MAX_COLS) ? MAX_COLS : int'(reg_cols);
    endfunction

    function automatic int rows_in_use();
        return (reg_rows > MAX_ROWS) ? MAX_ROWS : int'(reg_rows);
    endfunction

    function automatic int paint(int c, int r, logic [7:0] color);
        if (c < 0 || r < 0 || c >= cols_in_use() || r >= rows_in_use()) return 0;
        frame_px[r * MAX_COLS + c] = color;
        return 1;
    endfunction

    function automatic int trace_outline(int x, int y, int w, int h, logic [7:0] color);
        int clo, chi, rlo, rhi, r0, r1, c0, c1, r, c, n;
        n = 0;
        if (w == 0 || h == 0) return 0;
        clo = (w > 0) ? x : x + w + 1;
        chi = (w > 0) ? x + w - 1 : x;
        rlo = (h > 0) ? y : y + h + 1;
        rhi = (h > 0) ? y + h - 1 : y;
        r0 = (rlo < 0) ? 0 : rlo;
        r1 = (rhi > rows_in_use() - 1) ? rows_in_use() - 1 : rhi;
        c0 = (clo < 0) ? 0 : clo;
        c1 = (chi > cols_in_use() - 1) ? cols_in_use() - 1 : chi;
        for (r = r0; r <= r1; r++) begin
            if (r == rlo || r == rhi) begin
                for (c = c0; c <= c1; c++) n += paint(c, r, color);
            end else begin
                n += paint(clo, r, color);
                if (chi != clo) n += paint(chi, r, color);
            end
        end
        return n;
    endfunction

    function automatic pix_res_t apply_request(pix_req_t q);
        pix_res_t res;
        int x, y, n;
        x = q.col;
        y = q.row;
        res = '0;
        if (q.op == OP_DRAW) begin
            n = trace_outline(x, y, q.wid, q.hgt, q.color);
            res.count = (n > 8191) ? 13'd8191 : 13'(n);
        end else if (x < 0 || y < 0 || x >= cols_in_use() || y >= rows_in_use()) begin
            res.outside = 1'b1;
        end else begin
            res.pixel = frame_px[y * MAX_COLS + x];
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) result_q.push_back(apply_request(cur));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pend_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 99) < 30) begin
                    s_tvalid <= 1'b0;
                    send_gap <= pick_gap();
                end else begin
                    cur = pend_q.pop_front();
                    s_tdata  <= {cur.color, cur.hgt, cur.wid, cur.row, cur.col};
                    s_tuser  <= cur.op;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // result checker and backpressure
    always @(posedge aclk) begin
        pix_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    flag_mismatch("unexpected result", int'(m_tdata[20:8]), 0);
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[7:0] != want.pixel)
                        flag_mismatch("pixel_value", m_tdata[7:0], want.pixel);
                    if (m_tuser != want.outside)
                        flag_mismatch("outside_frame", m_tuser, want.outside);
                    if (m_tdata[20:8] != want.count)
                        flag_mismatch("drawn_count", m_tdata[20:8], want.count);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                sink_gap <= pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_req(logic op, int col, int row, int wid, int hgt, int color);
        pix_req_t q;
        q.op    = op;
        q.col   = 12'(col);
        q.row   = 12'(row);
        q.wid   = 12'(wid);
        q.hgt   = 12'(hgt);
        q.color = 8'(color);
        pend_q.push_back(q);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_frame(int cols, int rows);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_FRAME_COLS;
        cfg_wr_data <= CFG_W'(cols);
        reg_cols     = cols;
        @(posedge aclk);
        cfg_addr    <= REG_FRAME_ROWS;
        cfg_wr_data <= CFG_W'(rows);
        reg_rows     = rows;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly near the frame with small spans; some fully random words
    task automatic queue_random(int count, int read_pct);
        logic op;
        int col, row, wid, hgt;
        repeat (count) begin
            op = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_DRAW;
            if ($urandom_range(0, 9) == 0) begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
                wid = $urandom_range(0, 4095);
                hgt = $urandom_range(0, 4095);
            end else begin
                col = int'($urandom_range(0, 80)) - 8;
                row = int'($urandom_range(0, 80)) - 8;
                if ($urandom_range(0, 7) == 0) begin
                    wid = int'($urandom_range(0, 160)) - 80;
                    hgt = int'($urandom_range(0, 160)) - 80;
                end else begin
                    wid = int'($urandom_range(0, 30)) - 15;
                    hgt = int'($urandom_range(0, 30)) - 15;
                end
            end
            push_req(op, col, row, wid, hgt, $urandom_range(0, 255));
        end
    endtask

    task automatic run_phase(int cols, int rows, int count, int read_pct, bit calm);
        drain();
        no_idle = calm;
        set_frame(cols, rows);
        queue_random(count, read_pct);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests on the reset frame size
        push_req(OP_READ, 0, 0, 0, 0, 0);
        push_req(OP_READ, 63, 63, 0, 0, 0);
        push_req(OP_READ, -1, 0, 0, 0, 0);
        push_req(OP_READ, 64, 5, 0, 0, 0);
        push_req(OP_READ, -2048, 2047, 0, 0, 0);
        push_req(OP_READ, 2047, -2048, 0, 0, 0);
        push_req(OP_DRAW, 0, 0, 64, 64, 8'hff);
        push_req(OP_DRAW, 5, 5, 0, 7, 8'h11);
        push_req(OP_DRAW, 5, 5, 7, 0, 8'h11);
        push_req(OP_DRAW, 10, 10, -5, -3, 8'h55);
        push_req(OP_DRAW, 20, 20, 1, 1, 8'h01);
        push_req(OP_DRAW, 22, 22, -1, -1, 8'h80);
        push_req(OP_DRAW, 30, 30, 1, 5, 8'h7e);
        push_req(OP_DRAW, 30, 40, 5, 1, 8'h00);
        push_req(OP_DRAW, -2048, -2048, 2047, 2047, 8'haa);
        push_req(OP_DRAW, 2047, 2047, -2048, -2048, 8'hc3);
        push_req(OP_DRAW, 60, 60, 10, 10, 8'h33);
        // same outline and color again: still counted
        push_req(OP_DRAW, 60, 60, 10, 10, 8'h33);
        push_req(OP_READ, 0, 0, 0, 0, 0);
        push_req(OP_READ, 63, 0, 0, 0, 0);
        push_req(OP_READ, 10, 10, 0, 0, 0);
        push_req(OP_READ, 22, 22, 0, 0, 0);
        push_req(OP_READ, 61, 62, 0, 0, 0);
        push_req(OP_READ, 32, 32, 0, 0, 0);

        // receiver holds off while reads keep coming
        drain();
        no_idle  = 1'b1;
        set_frame(64, 64);
        hold_req = 1'b1;
        queue_random(50, 90);

        run_phase(64, 64, 70, 40, 1'b0);
        run_phase(1, 1, 40, 50, 1'b0);
        run_phase(0, 5, 30, 50, 1'b0);
        run_phase(5, 0, 30, 50, 1'b1);
        run_phase(127, 127, 80, 40, 1'b0);
        run_phase(100, 17, 60, 40, 1'b0);
        run_phase(33, 64, 60, 40, 1'b1);
        repeat (3) run_phase($urandom_range(0, 127), $urandom_range(0, 127), 40, 40, 1'b0);
        run_phase(64, 1, 30, 40, 1'b0);
        run_phase(1, 64, 30, 40, 1'b0);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/rod_pkg.sv
rtl/rod_ram.sv
rtl/rod_draw.sv
rtl/rectangle_outline_drawer.sv
dv/rectangle_outline_drawer_tb.sv
